// ===== src/ssmd_pkg.sv =====
// Shared types and constants for the seven-segment mode display unit.
`timescale 1ns / 1ps

package ssmd_pkg;

	typedef enum logic [1:0] {
		MODE_BIN    = 2'd0,
		MODE_BASE16 = 2'd1,
		MODE_BASE10 = 2'd2
	} mode_t;

	typedef enum logic {
		REQ_BUTTON = 1'b0,
		REQ_TICK   = 1'b1
	} req_t;

	localparam int unsigned NUM_DIGITS = 8;
	localparam int unsigned BTN_UP     = 0;
	localparam int unsigned BTN_CENTRE = 2;
	localparam int unsigned BTN_DOWN   = 4;

	localparam logic [7:0] GLYPH_BLANK = 8'hFF;

	// Decimal split: (v * DIV10_MUL) >> DIV10_SHIFT equals v / 10 for any 8-bit v
	localparam logic [7:0] DIV10_MUL   = 8'd205;
	localparam int unsigned DIV10_SHIFT = 11;

	typedef struct packed {
		logic [7:0] anode_select;
		logic [7:0] segments;
		logic [2:0] digit_number;
	} result_t;

	// Common-anode glyphs for 0..F, low bit is segment a, 0 lights a segment
	function automatic logic [7:0] glyph(input logic [3:0] nibble);
		logic [7:0] g;
		case (nibble)
			4'h0: g = 8'hC0;
			4'h1: g = 8'hF9;
			4'h2: g = 8'hA4;
			4'h3: g = 8'hB0;
			4'h4: g = 8'h99;
			4'h5: g = 8'h92;
			4'h6: g = 8'h82;
			4'h7: g = 8'hF8;
			4'h8: g = 8'h80;
			4'h9: g = 8'h90;
			4'hA: g = 8'h88;
			4'hB: g = 8'h83;
			4'hC: g = 8'hC6;
			4'hD: g = 8'hA1;
			4'hE: g = 8'h86;
			4'hF: g = 8'h8E;
			default: g = GLYPH_BLANK;
		endcase
		return g;
	endfunction

endpackage

// ===== src/seven_segment_mode_display_unit.sv =====
// Top level of the seven-segment mode display unit.
`timescale 1ns / 1ps

// Eight-digit multiplexed seven-segment driver.
// Input channel (in_valid/in_ready) carries either a button event or a scan
// tick; every transfer yields exactly one result on the output channel
// (out_valid/out_ready) describing the digit being driven.
// A button event with a pressed button (centre, then up, then down) latches
// the switches, selects binary, hex or decimal mode and rebuilds the segment
// buffer; its result already shows the rebuilt digit.
// A scan tick reports the lit digit, then counts towards dwell_ticks and
// steps the scan when the count is reached (0 behaves as 1).
// The result is registered, or held in the skid register while the output stalls.
// Throughput: one item per cycle while in_ready is high; the decode is a single registered pass.
// A two-entry output (result register plus skid register) keeps in_ready
// high while one result waits; in_ready falls only once both are full.
// Configuration: cfg_valid/dwell_ticks, always ready, write only while idle.
// Reset (arst_n low): buffer all blank, binary mode, digit 0,
// count 0, dwell_ticks 2, output empty.
module seven_segment_mode_display_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] dwell_ticks,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [4:0]  buttons_raw,
	input  logic [7:0]  switches,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  anode_select,
	output logic [7:0]  segments,
	output logic [2:0]  digit_number
);

	logic [15:0]          dwell_q;
	ssmd_pkg::mode_t      mode_q;
	logic [7:0]           buf_q [ssmd_pkg::NUM_DIGITS];
	logic [2:0]           digit_q;
	logic [15:0]          count_q;

	ssmd_pkg::result_t    out_q;
	ssmd_pkg::result_t    skid_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;

	logic                 in_take;
	logic                 out_free;
	logic                 hit;
	ssmd_pkg::mode_t      new_mode;
	logic [7:0]           new_buf [ssmd_pkg::NUM_DIGITS];
	logic [7:0]           built [ssmd_pkg::NUM_DIGITS];
	logic [4:0]           pressed;
	logic [15:0]          prod;
	logic [4:0]           quot;
	logic [1:0]           hund;
	logic [3:0]           tens;
	logic [3:0]           ones;
	logic [15:0]          limit;
	logic [16:0]          cnt_inc;
	logic                 advance;
	ssmd_pkg::result_t    res;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign in_take   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Button decode and buffer rebuild
	always_comb begin
		pressed  = ~buttons_raw;
		hit      = 1'b1;
		new_mode = mode_q;
		if (pressed[ssmd_pkg::BTN_CENTRE]) begin
			new_mode = ssmd_pkg::MODE_BIN;
		end else if (pressed[ssmd_pkg::BTN_UP]) begin
			new_mode = ssmd_pkg::MODE_BASE16;
		end else if (pressed[ssmd_pkg::BTN_DOWN]) begin
			new_mode = ssmd_pkg::MODE_BASE10;
		end else begin
			hit = 1'b0;
		end
		if (req_type != ssmd_pkg::REQ_BUTTON) begin
			hit = 1'b0;
		end

		prod = {8'd0, switches} * {8'd0, ssmd_pkg::DIV10_MUL};
		quot = prod[ssmd_pkg::DIV10_SHIFT +: 5];
		if (switches >= 8'd200) begin
			hund = 2'd2;
		end else if (switches >= 8'd100) begin
			hund = 2'd1;
		end else begin
			hund = 2'd0;
		end
		tens = 4'(quot - 5'(hund) * 5'd10);
		ones = 4'(switches - 8'(quot) * 8'd10);

		for (int i = 0; i < ssmd_pkg::NUM_DIGITS; i++) begin
			built[i] = ssmd_pkg::GLYPH_BLANK;
		end
		case (new_mode)
			ssmd_pkg::MODE_BIN: begin
				for (int i = 0; i < ssmd_pkg::NUM_DIGITS; i++) begin
					built[i] = ssmd_pkg::glyph({3'd0, switches[i]});
				end
			end
			ssmd_pkg::MODE_BASE16: begin
				built[0] = ssmd_pkg::glyph(switches[3:0]);
				built[1] = ssmd_pkg::glyph(switches[7:4]);
			end
			default: begin
				built[0] = ssmd_pkg::glyph(ones);
				built[1] = (quot != 5'd0) ? ssmd_pkg::glyph(tens) : ssmd_pkg::GLYPH_BLANK;
				built[2] = (hund != 2'd0) ? ssmd_pkg::glyph({2'd0, hund})
				                          : ssmd_pkg::GLYPH_BLANK;
			end
		endcase

		for (int i = 0; i < ssmd_pkg::NUM_DIGITS; i++) begin
			new_buf[i] = hit ? built[i] : buf_q[i];
		end

		res.anode_select = 8'd1 << digit_q;
		res.segments     = new_buf[digit_q];
		res.digit_number = digit_q;
	end

	// Scan dwell
	always_comb begin
		limit   = (dwell_q == 16'd0) ? 16'd1 : dwell_q;
		cnt_inc = {1'b0, count_q} + 17'd1;
		advance = cnt_inc >= {1'b0, limit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q <= 16'd2;
		end else if (cfg_valid && cfg_ready) begin
			dwell_q <= dwell_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ssmd_pkg::MODE_BIN;
			digit_q <= 3'd0;
			count_q <= 16'd0;
			for (int i = 0; i < ssmd_pkg::NUM_DIGITS; i++) begin
				buf_q[i] <= ssmd_pkg::GLYPH_BLANK;
			end
		end else if (in_take) begin
			if (hit) begin
				mode_q <= new_mode;
				for (int i = 0; i < ssmd_pkg::NUM_DIGITS; i++) begin
					buf_q[i] <= new_buf[i];
				end
			end
			if (req_type == ssmd_pkg::REQ_TICK) begin
				if (advance) begin
					count_q <= 16'd0;
					digit_q <= digit_q + 3'd1;
				end else begin
					count_q <= cnt_inc[15:0];
				end
			end
		end
	end

	// Result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_take;
			end
		end else if (in_take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_take) begin
				out_q <= res;
			end
		end else if (in_take) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign anode_select = out_q.anode_select;
	assign segments     = out_q.segments;
	assign digit_number = out_q.digit_number;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty result register");

	a_anode_matches_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (anode_select == (8'd1 << digit_number)))
		else $error("anode select does not match digit number");

	a_tick_moves_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && req_type == ssmd_pkg::REQ_TICK && advance)
		|=> (digit_q == $past(digit_q) + 3'd1) && (count_q == 16'd0))
		else $error("scan did not advance at end of dwell");

	a_button_keeps_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && req_type == ssmd_pkg::REQ_BUTTON) |=> $stable(digit_q) && $stable(count_q))
		else $error("button event disturbed the scan");

endmodule

// ===== test/ssmd_digit_checker.sv =====
// Digit predictor and result checker for the seven-segment mode display unit.
`timescale 1ns / 1ps

module ssmd_digit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] dwell_ticks,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [4:0]  buttons_raw,
	input  logic [7:0]  switches,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  anode_select,
	input  logic [7:0]  segments,
	input  logic [2:0]  digit_number,
	output int          fail_count,
	output int          pending
);

	localparam logic [7:0] SEG_CODE [16] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
		8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
	};

	logic [15:0]           dwell_limit;
	logic [7:0]            shown_value;
	ssmd_pkg::mode_t       mode;
	logic [7:0]            seg_buf [ssmd_pkg::NUM_DIGITS];
	logic [2:0]            scan_pos;
	logic [15:0]           dwell_cnt;
	ssmd_pkg::result_t     expected_digits [$];
	int                    errors = 0;

	assign fail_count = errors;

	task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
		errors++;
	endtask

	task automatic refill_digits();
		int unsigned v;
		v = shown_value;
		for (int i = 0; i < ssmd_pkg::NUM_DIGITS; i++)
			seg_buf[i] = ssmd_pkg::GLYPH_BLANK;
		case (mode)
			ssmd_pkg::MODE_BIN: begin
				for (int i = 0; i < ssmd_pkg::NUM_DIGITS; i++)
					seg_buf[i] = shown_value[i] ? SEG_CODE[1] : SEG_CODE[0];
			end
			ssmd_pkg::MODE_BASE16: begin
				seg_buf[0] = SEG_CODE[v % 16];
				seg_buf[1] = SEG_CODE[v / 16];
			end
			default: begin
				// leading places blank once the value runs out of digits
				seg_buf[0] = SEG_CODE[v % 10];
				if (v >= 10)
					seg_buf[1] = SEG_CODE[(v / 10) % 10];
				if (v >= 100)
					seg_buf[2] = SEG_CODE[v / 100];
			end
		endcase
	endtask

	task automatic predict_digit(input logic kind, input logic [4:0] btn, input logic [7:0] sw);
		logic [4:0]        pressed;
		logic              take;
		logic [16:0]       next_cnt;
		logic [16:0]       limit;
		ssmd_pkg::result_t r;
		if (kind == ssmd_pkg::REQ_BUTTON) begin
			pressed = ~btn;
			take = 1'b1;
			if (pressed[ssmd_pkg::BTN_CENTRE])
				mode = ssmd_pkg::MODE_BIN;
			else if (pressed[ssmd_pkg::BTN_UP])
				mode = ssmd_pkg::MODE_BASE16;
			else if (pressed[ssmd_pkg::BTN_DOWN])
				mode = ssmd_pkg::MODE_BASE10;
			else
				take = 1'b0;
			if (take) begin
				shown_value = sw;
				refill_digits();
			end
		end
		r.anode_select = 8'b1 << scan_pos;
		r.segments = seg_buf[scan_pos];
		r.digit_number = scan_pos;
		if (kind == ssmd_pkg::REQ_TICK) begin
			next_cnt = {1'b0, dwell_cnt} + 17'd1;
			limit = (dwell_limit == 16'd0) ? 17'd1 : {1'b0, dwell_limit};
			if (next_cnt >= limit) begin
				dwell_cnt = '0;
				scan_pos = scan_pos + 3'd1;
			end else begin
				dwell_cnt = next_cnt[15:0];
			end
		end
		expected_digits.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		ssmd_pkg::result_t want;
		if (!arst_n) begin
			dwell_limit = 16'd2;
			shown_value = '0;
			mode = ssmd_pkg::MODE_BIN;
			for (int i = 0; i < ssmd_pkg::NUM_DIGITS; i++)
				seg_buf[i] = ssmd_pkg::GLYPH_BLANK;
			scan_pos = '0;
			dwell_cnt = '0;
			expected_digits.delete();
			pending <= 0;
		end else begin
			// the result leaving now always stems from an earlier transfer
			if (out_valid && out_ready) begin
				if (expected_digits.size() == 0) begin
					report("result with nothing expected", anode_select, 8'h00);
				end else begin
					want = expected_digits.pop_front();
					if (anode_select !== want.anode_select)
						report("anode_select", anode_select, want.anode_select);
					if (segments !== want.segments)
						report("segments", segments, want.segments);
					if (digit_number !== want.digit_number)
						report("digit_number", {5'b0, digit_number}, {5'b0, want.digit_number});
				end
			end
			if (cfg_valid && cfg_ready)
				dwell_limit = dwell_ticks;
			if (in_valid && in_ready)
				predict_digit(req_type, buttons_raw, switches);
			pending <= expected_digits.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Stimulus and verdict for the seven-segment mode display unit.
`timescale 1ns / 1ps

module tb;

	localparam logic [15:0] DWELL_PLAN [5] = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd7};
	localparam int PHASE_ITEMS = 210;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] dwell_ticks;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [4:0]  buttons_raw;
	logic [7:0]  switches;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  anode_select;
	logic [7:0]  segments;
	logic [2:0]  digit_number;
	int          fail_count;
	int          pending;
	int          burst_left = 0;
	logic        squeeze = 1'b0;

	seven_segment_mode_display_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.dwell_ticks  (dwell_ticks),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.buttons_raw  (buttons_raw),
		.switches     (switches),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.anode_select (anode_select),
		.segments     (segments),
		.digit_number (digit_number)
	);

	ssmd_digit_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.dwell_ticks  (dwell_ticks),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.buttons_raw  (buttons_raw),
		.switches     (switches),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.anode_select (anode_select),
		.segments     (segments),
		.digit_number (digit_number),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int send_pause();
		int pick;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic kind, input logic [4:0] btn, input logic [7:0] sw);
		int gap;
		gap = send_pause();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		buttons_raw <= btn;
		switches <= sw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic offer_random();
		logic       kind;
		logic [4:0] btn;
		int         pick;
		pick = $urandom_range(0, 99);
		kind = (pick < 55) ? ssmd_pkg::REQ_TICK : ssmd_pkg::REQ_BUTTON;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			btn = 5'h1F;
		else if (pick < 50)
			btn = ~(5'b1 << (2 * $urandom_range(0, 2)));
		else
			btn = 5'($urandom_range(0, 31));
		send_item(kind, btn, 8'($urandom_range(0, 255)));
	endtask

	// only while idle: input lowered and every result drained
	task automatic write_dwell(input logic [15:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_valid <= 1'b1;
		dwell_ticks <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: random stalls, long bursts of readiness, two forced long hold-offs
	initial begin
		int hold;
		int pick;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze) begin
				squeeze = 1'b0;
				out_ready <= 1'b0;
				hold = 120;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					out_ready <= 1'b1;
					hold = $urandom_range(1, 12);
				end else if (pick < 55) begin
					out_ready <= 1'b1;
					hold = $urandom_range(50, 200);
				end else if (pick < 93) begin
					out_ready <= 1'b0;
					hold = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b0;
					hold = $urandom_range(15, 60);
				end
			end
			repeat (hold - 1) @(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		dwell_ticks = '0;
		in_valid = 1'b0;
		req_type = ssmd_pkg::REQ_TICK;
		buttons_raw = 5'h1F;
		switches = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset contents, each button, priority and the decimal blanking
		send_item(ssmd_pkg::REQ_TICK,   5'h1F, 8'h00);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h1F, 8'hAB);
		send_item(ssmd_pkg::REQ_TICK,   5'h00, 8'hFF);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h1B, 8'hFF);
		send_item(ssmd_pkg::REQ_TICK,   5'h1F, 8'h00);
		send_item(ssmd_pkg::REQ_TICK,   5'h1F, 8'h00);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h1E, 8'hA5);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h0F, 8'd255);
		send_item(ssmd_pkg::REQ_TICK,   5'h1F, 8'h00);
		send_item(ssmd_pkg::REQ_TICK,   5'h1F, 8'h00);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h0F, 8'd0);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h0F, 8'd105);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h0F, 8'd7);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h00, 8'h5A);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h0E, 8'hC3);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h0B, 8'h01);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h15, 8'h77);
		send_item(ssmd_pkg::REQ_BUTTON, 5'h0F, 8'd40);
		repeat (7) send_item(ssmd_pkg::REQ_TICK, 5'h1F, 8'h00);

		// the largest dwell leaves the count high, so the following lower setting
		// advances the scan on its first tick
		for (int p = 0; p < 6; p++) begin
			if (p < 5)
				write_dwell(DWELL_PLAN[p]);
			else
				write_dwell(16'($urandom_range(1, 5)));
			if (p == 0 || p == 3)
				squeeze = 1'b1;
			repeat (PHASE_ITEMS) offer_random();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ssmd_pkg.sv
src/seven_segment_mode_display_unit.sv
test/ssmd_digit_checker.sv
test/tb.sv
